// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files of the clamped PID core.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is active.
`define CPID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check written as an implication from a condition to a consequence.
`define CPID_ASSERT_IMPL(lbl, ante, cons, msg) \
    `CPID_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/cpid_pkg.sv -----
// Package for the clamped PID core: register indexes, widths and the config struct.
// No dependencies; used by every module of the core.
package cpid_pkg;

    // Fraction bits of the gains (Q16.16 by default).
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_SLOT     = 8'd7;

    // Reset values of the limits.
    localparam logic [14:0] ERROR_LIMIT_RST = 15'h7FFF;
    localparam logic [14:0] DRIVE_LIMIT_RST = 15'h7FFF;

    // Stream widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // Current configuration as seen by the pipeline stages.
    typedef struct packed {
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic [14:0]        error_limit;
        logic [14:0]        dead_band;
        logic [30:0]        integral_limit;
        logic [14:0]        drive_limit;
        logic [1:0]         motor_slot;
    } cfg_t;

endpackage

// ----- rtl/cpid_cfg_regs.sv -----
// Configuration register file of the clamped PID core.
// Depends on cpid_pkg for register indexes and the cfg_t struct.
module cpid_cfg_regs
    import cpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    // Reset contents: zero gains and limits, except the error and drive clamps.
    localparam cfg_t CFG_RST = '{
        gain_p:         '0,
        gain_i:         '0,
        gain_d:         '0,
        error_limit:    ERROR_LIMIT_RST,
        dead_band:      '0,
        integral_limit: '0,
        drive_limit:    DRIVE_LIMIT_RST,
        motor_slot:     '0
    };

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes leave everything alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_GAIN_P:         cfg_next.gain_p         = signed'(wr_data);
                REG_GAIN_I:         cfg_next.gain_i         = signed'(wr_data);
                REG_GAIN_D:         cfg_next.gain_d         = signed'(wr_data);
                REG_ERROR_LIMIT:    cfg_next.error_limit    = wr_data[14:0];
                REG_DEAD_BAND:      cfg_next.dead_band      = wr_data[14:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = wr_data[30:0];
                REG_DRIVE_LIMIT:    cfg_next.drive_limit    = wr_data[14:0];
                REG_MOTOR_SLOT:     cfg_next.motor_slot     = wr_data[1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with the documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/cpid_err_stage.sv -----
// Error stage: clamp, deadband, integral update and derivative, with the loop state.
// Depends on cpid_pkg for the cfg_t struct.
module cpid_err_stage
    import cpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] feedback,
    input  logic signed [15:0] setpoint,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] err,
    output logic signed [31:0] integ,
    output logic signed [16:0] deriv
);

    logic               valid_reg;
    logic signed [31:0] integral_reg;
    logic signed [31:0] integral_next;
    logic signed [15:0] prev_err_reg;
    logic signed [15:0] err_reg;
    logic signed [15:0] err_next;
    logic signed [31:0] integ_reg;
    logic signed [16:0] deriv_reg;
    logic signed [16:0] deriv_next;
    logic signed [16:0] diff;
    logic signed [16:0] elim;
    logic signed [16:0] err_clamp;
    logic [14:0]        err_abs;
    logic signed [32:0] isum;
    logic signed [32:0] ilim;
    logic signed [32:0] isat;
    logic               take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Error, clamped symmetrically and then zeroed inside the deadband.
    always_comb
    begin
        diff = {setpoint[15], setpoint} - {feedback[15], feedback};
        elim = signed'({2'b00, cfg.error_limit});
        if (diff > elim)
            err_clamp = elim;
        else if (diff < -elim)
            err_clamp = -elim;
        else
            err_clamp = diff;
        err_abs = err_clamp[16] ? 15'(-err_clamp) : err_clamp[14:0];
        if ((err_clamp != '0) && (err_abs < cfg.dead_band))
            err_next = '0;
        else
            err_next = err_clamp[15:0];
    end

    // Saturating integral and the derivative from the last error.
    always_comb
    begin
        isum = {integral_reg[31], integral_reg} + {{17{err_next[15]}}, err_next};
        ilim = signed'({2'b00, cfg.integral_limit});
        if (isum > ilim)
            isat = ilim;
        else if (isum < -ilim)
            isat = -ilim;
        else
            isat = isum;
        integral_next = isat[31:0];
        deriv_next    = {err_next[15], err_next} - {prev_err_reg[15], prev_err_reg};
    end

    // Loop state and stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (take)
            begin
                integral_reg <= integral_next;
                prev_err_reg <= err_next;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            err_reg   <= err_next;
            integ_reg <= integral_next;
            deriv_reg <= deriv_next;
        end
    end

    assign out_valid = valid_reg;
    assign err       = err_reg;
    assign integ     = integ_reg;
    assign deriv     = deriv_reg;

endmodule

// ----- rtl/cpid_mul_stage.sv -----
// Multiply stage: the three gain products, each registered.
// Depends on cpid_pkg for the cfg_t struct.
module cpid_mul_stage
    import cpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] err,
    input  logic signed [31:0] integ,
    input  logic signed [16:0] deriv,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] p_term,
    output logic signed [63:0] i_term,
    output logic signed [48:0] d_term
);

    logic               valid_reg;
    logic signed [47:0] p_reg;
    logic signed [47:0] p_next;
    logic signed [63:0] i_reg;
    logic signed [63:0] i_next;
    logic signed [48:0] d_reg;
    logic signed [48:0] d_next;
    logic               take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // One multiplier per term.
    always_comb
    begin
        p_next = cfg.gain_p * err;
        i_next = cfg.gain_i * integ;
        d_next = cfg.gain_d * deriv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p_reg <= p_next;
            i_reg <= i_next;
            d_reg <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign p_term    = p_reg;
    assign i_term    = i_reg;
    assign d_term    = d_reg;

endmodule

// ----- rtl/cpid_out_stage.sv -----
// Output stage: sum of terms, drive saturation, truncation and the frame byte offset.
// Depends on cpid_pkg for the cfg_t struct; this is the result register.
module cpid_out_stage
    import cpid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [47:0] p_term,
    input  logic signed [63:0] i_term,
    input  logic signed [48:0] d_term,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] drive,
    output logic [2:0]         byte_offset
);

    localparam logic signed [63:0] FRAC_MASK = 64'((64'(1) << GAIN_FRAC_BITS) - 64'(1));

    logic               valid_reg;
    logic signed [15:0] drive_reg;
    logic signed [15:0] drive_next;
    logic [2:0]         offset_reg;
    logic signed [63:0] sum;
    logic signed [63:0] lim_q;
    logic signed [63:0] biased;
    logic signed [63:0] quot;
    logic signed [15:0] dlim;
    logic               take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Saturate at full precision, otherwise truncate toward zero.
    always_comb
    begin
        sum    = {{16{p_term[47]}}, p_term} + i_term + {{15{d_term[48]}}, d_term};
        lim_q  = signed'(64'(cfg.drive_limit) << GAIN_FRAC_BITS);
        dlim   = signed'({1'b0, cfg.drive_limit});
        biased = sum + (sum[63] ? FRAC_MASK : 64'sd0);
        quot   = biased >>> GAIN_FRAC_BITS;
        if (sum > lim_q)
            drive_next = dlim;
        else if (sum < -lim_q)
            drive_next = -dlim;
        else
            drive_next = quot[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            drive_reg  <= drive_next;
            offset_reg <= {cfg.motor_slot, 1'b0};
        end
    end

    assign out_valid   = valid_reg;
    assign drive       = drive_reg;
    assign byte_offset = offset_reg;

endmodule

// ----- rtl/clamped_pid_with_deadband_core.sv -----
// Clamped PID core with deadband: m_tvalid rises once an accepted input item has passed
// the error, multiply and output registers, the first loaded at the edge that accepts it.
// Throughput is one item per cycle; each stage holds one item and moves on when
// the next stage has room, so a stalled result blocks intake once all three stages are full.
// Reset clears the integral, the previous error, all stage valids and the registers
// to their reset values (gains 0, error and drive limits 32767, others 0).
module clamped_pid_with_deadband_core
    import cpid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] feedback, [31:16] setpoint
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] drive, [18:16] byte_offset,
                                             // [26:19] drive_high_byte,
                                             // [34:27] drive_low_byte, [39:35] zero
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    cfg_t               cfg;
    logic               e_valid;
    logic               e_ready;
    logic signed [15:0] e_err;
    logic signed [31:0] e_integ;
    logic signed [16:0] e_deriv;
    logic               m_valid;
    logic               m_ready;
    logic signed [47:0] m_p;
    logic signed [63:0] m_i;
    logic signed [48:0] m_d;
    logic signed [15:0] drive;
    logic [2:0]         byte_offset;
    logic [14:0]        err_mag;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    cpid_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cpid_err_stage u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .feedback  (signed'(s_tdata[15:0])),
        .setpoint  (signed'(s_tdata[31:16])),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .err       (e_err),
        .integ     (e_integ),
        .deriv     (e_deriv)
    );

    cpid_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (e_valid),
        .in_ready  (e_ready),
        .err       (e_err),
        .integ     (e_integ),
        .deriv     (e_deriv),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .p_term    (m_p),
        .i_term    (m_i),
        .d_term    (m_d)
    );

    cpid_out_stage #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (m_valid),
        .in_ready    (m_ready),
        .p_term      (m_p),
        .i_term      (m_i),
        .d_term      (m_d),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .drive       (drive),
        .byte_offset (byte_offset)
    );

    // Pack the result item; the two frame bytes are the big-endian halves of drive.
    assign m_tdata = {5'b00000, drive[7:0], drive[15:8], byte_offset, drive};

    // Magnitude of the error held in the error stage.
    assign err_mag = e_err[15] ? 15'(-e_err) : e_err[14:0];

    // A result never exceeds the drive limit in either direction.
    `CPID_ASSERT_IMPL(a_drive_in_limit, m_tvalid,
        (($signed(drive) <= $signed({1'b0, cfg.drive_limit})) &&
         ($signed(drive) >= -$signed({1'b0, cfg.drive_limit}))),
        "drive outside drive_limit")

    // A nonzero error left after the deadband is outside it and inside the clamp.
    `CPID_ASSERT_IMPL(a_err_deadband, (e_valid && (e_err != '0)),
        ((err_mag >= cfg.dead_band) && (err_mag <= cfg.error_limit)),
        "error inside deadband or beyond error_limit")

    // An empty error stage always takes a new item.
    `CPID_ASSERT_IMPL(a_intake_free, !e_valid, s_tready,
        "input stalled with an empty error stage")

endmodule

// ----- test/clamped_pid_with_deadband_core_test.sv -----
// Self-checking testbench for the clamped PID core with deadband.
// Depends on cpid_pkg and clamped_pid_with_deadband_core; drives both streams and the
// register channel, predicts each drive item and compares it against the result stream.
module clamped_pid_with_deadband_core_test;
    import cpid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = GAIN_FRAC_BITS_DEF;
    localparam int PIPE_LAT  = 3;
    localparam int PHASE_TICKS = 225;
    localparam int RANDOM_PHASES = 8;
    localparam int MAX_REPORTS = 10;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = REG_MOTOR_SLOT + 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP   = 8'hFF;

    // One control tick as carried on s_tdata, feedback in the low half.
    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] feedback;
    } tick_t;

    // One drive item as carried on m_tdata, drive in the low bits.
    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  low_byte;
        logic [7:0]  high_byte;
        logic [2:0]  byte_offset;
        logic [15:0] drive;
    } drive_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Pending ticks for the driver and drive items still owed by the core.
    tick_t       tick_q[$];
    drive_item_t drive_expect_q[$];

    // Predictor copy of the registers and the controller state.
    longint      kp, ki, kd;
    longint      err_lim, dead_lim, int_lim, drv_lim;
    logic [1:0]  slot;
    longint      integ, prev_err;

    int          in_idle_pct = 17;
    int          out_idle_pct = 17;
    logic        in_fire = 1'b0;
    int          mismatch_count = 0;
    int          ticks_taken = 0;
    int          drives_checked = 0;
    int          reg_writes = 0;
    int          saturations = 0;
    int          settings_used = 0;

    clamped_pid_with_deadband_core #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Register file as seen by the predictor, starting from the reset values.
    task automatic pid_reset_regs();
        kp = 0;
        ki = 0;
        kd = 0;
        err_lim = 32767;
        dead_lim = 0;
        int_lim = 0;
        drv_lim = 32767;
        slot = '0;
        integ = 0;
        prev_err = 0;
    endtask

    task automatic pid_apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            REG_GAIN_P:         kp = longint'($signed(data));
            REG_GAIN_I:         ki = longint'($signed(data));
            REG_GAIN_D:         kd = longint'($signed(data));
            REG_ERROR_LIMIT:    err_lim = longint'(data[14:0]);
            REG_DEAD_BAND:      dead_lim = longint'(data[14:0]);
            REG_INTEGRAL_LIMIT: int_lim = longint'(data[30:0]);
            REG_DRIVE_LIMIT:    drv_lim = longint'(data[14:0]);
            REG_MOTOR_SLOT:     slot = data[1:0];
            default:            ;
        endcase
    endtask

    // One controller tick: clamp, deadband, saturating integral, derivative, drive clamp.
    task automatic pid_tick(input tick_t t);
        longint      err;
        longint      deriv;
        longint      sum;
        longint      one;
        longint      lim_q;
        longint      drv;
        drive_item_t d;
        err = longint'(t.setpoint) - longint'(t.feedback);
        if (err > err_lim)
            err = err_lim;
        else if (err < -err_lim)
            err = -err_lim;
        // The deadband is tested after the clamp and works on both signs.
        if (err > 0 && err < dead_lim)
            err = 0;
        if (err < 0 && err > -dead_lim)
            err = 0;
        integ = integ + err;
        if (integ > int_lim)
            integ = int_lim;
        else if (integ < -int_lim)
            integ = -int_lim;
        deriv = err - prev_err;
        prev_err = err;
        sum = kp * err + ki * integ + kd * deriv;
        one = longint'(1) <<< FRAC_BITS;
        lim_q = drv_lim * one;
        if (sum > lim_q)
        begin
            drv = drv_lim;
            saturations++;
        end
        else if (sum < -lim_q)
        begin
            drv = -drv_lim;
            saturations++;
        end
        else
            drv = sum / one;
        d.pad = '0;
        d.drive = drv[15:0];
        d.byte_offset = {slot, 1'b0};
        d.high_byte = drv[15:8];
        d.low_byte = drv[7:0];
        drive_expect_q.push_back(d);
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    task automatic check_drive(input drive_item_t got);
        drive_item_t want;
        if (drive_expect_q.size() == 0)
        begin
            report_mismatch("unexpected drive item, drive", 0, $signed(got.drive));
            return;
        end
        want = drive_expect_q.pop_front();
        drives_checked++;
        if (got.drive !== want.drive)
            report_mismatch("drive", $signed(want.drive), $signed(got.drive));
        if (got.byte_offset !== want.byte_offset)
            report_mismatch("byte_offset", want.byte_offset, got.byte_offset);
        if (got.high_byte !== want.high_byte)
            report_mismatch("drive_high_byte", want.high_byte, got.high_byte);
        if (got.low_byte !== want.low_byte)
            report_mismatch("drive_low_byte", want.low_byte, got.low_byte);
        if (got.pad !== want.pad)
            report_mismatch("tdata padding", want.pad, got.pad);
    endtask

    // Driver: presents the next pending tick after the current one is taken, and sets m_tready.
    always @(negedge clk)
    begin : tick_driver
        tick_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (tick_q.size() != 0 && $urandom_range(99) >= in_idle_pct)
            begin
                nxt = tick_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nxt;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= rst_n && ($urandom_range(99) >= out_idle_pct);
    end

    // Monitor: checks drive items first, then predicts for a tick taken at this edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_drive(drive_item_t'(m_tdata));
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                pid_tick(tick_t'(s_tdata));
                ticks_taken++;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pid_apply_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_tick(input int fb, input int sp);
        tick_t t;
        t.feedback = fb[15:0];
        t.setpoint = sp[15:0];
        tick_q.push_back(t);
    endtask

    // Waits until every tick is taken and every drive item has come back.
    task automatic drain();
        while (tick_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (drive_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return $urandom;
            default: return $urandom_range(262144) - 32'd131072;
        endcase
    endfunction

    function automatic logic [31:0] pick_lim15();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'd32767;
            2: return $urandom_range(32767);
            default: return $urandom_range(400);
        endcase
    endfunction

    function automatic logic [31:0] pick_int_lim();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(200000);
        endcase
    endfunction

    // Sets random bits above a register's width; the core must drop them.
    function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
        logic [31:0] r;
        r = $urandom;
        return (r << w) | v;
    endfunction

    task automatic randomize_setup();
        logic [31:0] db;
        write_reg(REG_GAIN_P, pick_gain());
        write_reg(REG_GAIN_I, pick_gain());
        write_reg(REG_GAIN_D, pick_gain());
        write_reg(REG_ERROR_LIMIT, with_junk(pick_lim15(), 15));
        db = ($urandom_range(2) == 0) ? pick_lim15() : $urandom_range(40);
        write_reg(REG_DEAD_BAND, with_junk(db, 15));
        write_reg(REG_INTEGRAL_LIMIT, with_junk(pick_int_lim(), 31));
        write_reg(REG_DRIVE_LIMIT, with_junk(pick_lim15(), 15));
        write_reg(REG_MOTOR_SLOT, with_junk($urandom_range(3), 2));
        if ($urandom_range(2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_IDX_TOP, REG_PAST_LAST)), $urandom);
        settings_used++;
    endtask

    // Random ticks: full-range pairs, near pairs that exercise the deadband, and extremes.
    task automatic push_random(input int n);
        int fb;
        int sp;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0:
                begin
                    fb = $signed(16'($urandom));
                    sp = $signed(16'($urandom));
                end
                3:
                begin
                    fb = ($urandom_range(1)) ? 32767 : -32768;
                    sp = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1)) ? 32767 : -32768);
                end
                default:
                begin
                    fb = $signed(16'($urandom));
                    sp = fb + int'($urandom_range(600)) - 300;
                    if (sp > 32767)
                        sp = 32767;
                    if (sp < -32768)
                        sp = -32768;
                end
            endcase
            push_tick(fb, sp);
        end
    endtask

    initial
    begin
        pid_reset_regs();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero gains give zero drive in slot zero.
        settings_used++;
        push_tick(0, 0);
        push_tick(-32768, 32767);
        push_tick(32767, -32768);
        settle();

        // Moderate gains with every limit in play, plus ignored out-of-map writes.
        write_reg(REG_GAIN_P, 32'h0001_0000);
        write_reg(REG_GAIN_I, 32'h0000_1000);
        write_reg(REG_GAIN_D, 32'h0000_8000);
        write_reg(REG_ERROR_LIMIT, 32'd1000);
        write_reg(REG_DEAD_BAND, 32'd10);
        write_reg(REG_INTEGRAL_LIMIT, 32'd5000);
        write_reg(REG_DRIVE_LIMIT, 32'd2000);
        write_reg(REG_MOTOR_SLOT, 32'd3);
        write_reg(REG_PAST_LAST, 32'h0000_7FFF);
        write_reg(REG_IDX_TOP, 32'h0001_0000);
        settings_used++;
        push_tick(0, 9);
        push_tick(0, -9);
        push_tick(0, 10);
        push_tick(0, -10);
        push_tick(0, 1);
        push_tick(0, -1);
        push_tick(-32768, 32767);
        push_tick(-32768, 32767);
        push_tick(-32768, 32767);
        push_tick(32767, -32768);
        push_tick(0, 500);
        push_tick(0, -500);
        settle();

        // A deadband wider than the error clamp zeroes every error.
        write_reg(REG_ERROR_LIMIT, 32'd5);
        write_reg(REG_DEAD_BAND, 32'd6);
        settings_used++;
        push_tick(0, 3);
        push_tick(0, -100);
        push_tick(0, 100);
        settle();

        // Zero limits pin error, integral and drive to zero.
        write_reg(REG_ERROR_LIMIT, 32'd0);
        write_reg(REG_INTEGRAL_LIMIT, 32'd0);
        write_reg(REG_DRIVE_LIMIT, 32'd0);
        write_reg(REG_MOTOR_SLOT, 32'd1);
        settings_used++;
        push_tick(-32768, 32767);
        push_tick(1000, -1000);
        settle();

        // Extreme gains and widest limits, then random settings per phase.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
                write_reg(REG_GAIN_I, 32'h8000_0000);
                write_reg(REG_GAIN_D, 32'h8000_0000);
                write_reg(REG_ERROR_LIMIT, 32'd32767);
                write_reg(REG_DEAD_BAND, 32'd0);
                write_reg(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
                write_reg(REG_DRIVE_LIMIT, 32'd32767);
                write_reg(REG_MOTOR_SLOT, 32'd2);
                settings_used++;
            end
            else
                randomize_setup();
            in_idle_pct = (ph == 3) ? 0 : 17;
            out_idle_pct = (ph == 3) ? 0 : 17;
            if (ph == 5)
            begin
                // Sender holds off until the core has returned everything.
                push_random(PHASE_TICKS / 2);
                drain();
                push_random(PHASE_TICKS - PHASE_TICKS / 2);
            end
            else
                push_random(PHASE_TICKS);
            settle();
        end

        drain();
        repeat (PIPE_LAT + 5) @(posedge clk);
        $display("Ran %0d control ticks under %0d register settings (%0d writes);",
                 ticks_taken, settings_used, reg_writes);
        $display("checked %0d drive items, %0d of them at the drive clamp.",
                 drives_checked, saturations);
        if (mismatch_count == 0 && drive_expect_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog for a core that stops answering.
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cpid_pkg.sv
rtl/cpid_cfg_regs.sv
rtl/cpid_err_stage.sv
rtl/cpid_mul_stage.sv
rtl/cpid_out_stage.sv
rtl/clamped_pid_with_deadband_core.sv
test/clamped_pid_with_deadband_core_test.sv
